/* sv/ibad_pkg.sv */
// Shared types and constants for the block-average image downscaler.
// Holds sizes, register indexes, channel codes, the control state type and
// the configuration and divider request structs. No dependencies.
package ibad_pkg;

    // Grid and field sizes
    localparam int GRID_SIZE  = 16;
    localparam int GRID_W     = $clog2(GRID_SIZE);
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 13;
    localparam int MIN_SIZE   = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int POS_W      = 12;
    localparam int CNT_W      = 9;
    localparam int ACC_W      = 17;
    localparam int CH_W       = 2;
    localparam int DIV_CNT_W  = $clog2(ACC_W);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL = 2'd2;

    // Channel codes; any other code selects blue
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN_DIV,
        S_EMIT_RD,
        S_EMIT_START,
        S_EMIT_DIV
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [CH_W-1:0]   channel_select;
        logic              restart;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

/* sv/ibad_acc_ram.sv */
// Column accumulator memory: one write port and one registered read port.
// Depends on ibad_pkg for depth and data width.
module ibad_acc_ram (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ibad_pkg::GRID_W-1:0]  rd_addr,
    output logic [ibad_pkg::ACC_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [ibad_pkg::GRID_W-1:0]  wr_addr,
    input  logic [ibad_pkg::ACC_W-1:0]   wr_data
);

    logic [ibad_pkg::ACC_W-1:0] acc_mem [ibad_pkg::GRID_SIZE];
    logic [ibad_pkg::ACC_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= acc_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ibad_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by bin and band work.
// Depends on ibad_pkg for widths and the request struct.
module ibad_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ibad_pkg::div_req_t          req,
    output logic                        busy,
    output logic                        done,
    output logic [ibad_pkg::ACC_W-1:0]  quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ibad_pkg::DIV_CNT_W-1:0]    count_reg;
    logic [ibad_pkg::ACC_W-1:0]        quo_reg;
    logic [ibad_pkg::CNT_W-1:0]        rem_reg;
    logic [ibad_pkg::CNT_W-1:0]        divisor_reg;

    logic [ibad_pkg::CNT_W:0]          trial;
    logic [ibad_pkg::CNT_W:0]          diff;
    logic                              fits;
    logic [ibad_pkg::CNT_W-1:0]        rem_next;
    logic [ibad_pkg::ACC_W-1:0]        quo_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ibad_pkg::ACC_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? diff[ibad_pkg::CNT_W-1:0] : trial[ibad_pkg::CNT_W-1:0];
        quo_next = {quo_reg[ibad_pkg::ACC_W-2:0], fits};
    end

    // Control: start loads, step until the last bit, then flag done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (count_reg == ibad_pkg::DIV_CNT_W'(ibad_pkg::ACC_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/ibad_cfg_regs.sv */
// APB-style configuration registers: image width, image height, channel.
// A size write raises a one-cycle restart. Depends on ibad_pkg.
module ibad_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ibad_pkg::ADDR_W-1:0]   paddr,
    input  logic [ibad_pkg::DATA_W-1:0]   pwdata,
    output logic [ibad_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ibad_pkg::cfg_t                cfg
);

    logic [ibad_pkg::SIZE_W-1:0] width_reg;
    logic [ibad_pkg::SIZE_W-1:0] height_reg;
    logic [ibad_pkg::CH_W-1:0]   channel_reg;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE);
            height_reg  <= ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE);
            channel_reg <= ibad_pkg::CH_RED;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ibad_pkg::REG_WIDTH:   width_reg   <= pwdata[ibad_pkg::SIZE_W-1:0];
                ibad_pkg::REG_HEIGHT:  height_reg  <= pwdata[ibad_pkg::SIZE_W-1:0];
                ibad_pkg::REG_CHANNEL: channel_reg <= pwdata[ibad_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            ibad_pkg::REG_WIDTH:   prdata = ibad_pkg::DATA_W'(width_reg);
            ibad_pkg::REG_HEIGHT:  prdata = ibad_pkg::DATA_W'(height_reg);
            ibad_pkg::REG_CHANNEL: prdata = ibad_pkg::DATA_W'(channel_reg);
            default:               prdata = '0;
        endcase
    end

    // Drive the configuration view; a size write restarts the frame
    always_comb
    begin
        cfg.image_width    = width_reg;
        cfg.image_height   = height_reg;
        cfg.channel_select = channel_reg;
        cfg.restart        = wr_en &&
                             (reg_idx == ibad_pkg::REG_WIDTH ||
                              reg_idx == ibad_pkg::REG_HEIGHT);
    end

endmodule

/* sv/image_block_average_downscale_top.sv */
// Top level of the block-average downscaler to a 16x16 grid.
// Depends on ibad_pkg, ibad_cfg_regs, ibad_acc_ram and ibad_divider.
//
// Usage:
//   Pixels (red, green, blue) enter in raster order on the input channel
//   (in_valid / in_stall). One channel, picked by channel_select, is summed
//   per horizontal bin; the truncated bin average is added into one of 16
//   column accumulators held in a small synchronous memory.
//   When a band of rows ends, 16 results leave on the output channel
//   (out_valid / out_stall) in column order, each the accumulator divided
//   by the band's row count, tagged with grid row and column.
//   Pixels inside a bin are taken back to back. A pixel that closes a bin
//   holds the input for the 17-step serial divider and the accumulator
//   read-modify-write. After the last pixel of a band, each column result is
//   read, divided and loaded in turn; the next read waits for that load.
//   in_stall is high while a division or a band readout is in progress.
//   A result waits in the output register while out_stall is high; the
//   readout halts until that register frees up.
//   Reset: width and height 16, red channel, empty frame, all accumulators
//   read as zero. A write to the width or height register restarts the frame.
module image_block_average_downscale_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ibad_pkg::ADDR_W-1:0]   paddr,
    input  logic [ibad_pkg::DATA_W-1:0]   pwdata,
    output logic [ibad_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // pixel requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ibad_pkg::PIX_W-1:0]    red,
    input  logic [ibad_pkg::PIX_W-1:0]    green,
    input  logic [ibad_pkg::PIX_W-1:0]    blue,
    // result requests
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ibad_pkg::PIX_W-1:0]    average,
    output logic [ibad_pkg::GRID_W-1:0]   out_row,
    output logic [ibad_pkg::GRID_W-1:0]   out_col,
    output logic                          band_last,
    output logic                          frame_last
);

    localparam logic [ibad_pkg::GRID_W-1:0] LAST_CELL = ibad_pkg::GRID_W'(ibad_pkg::GRID_SIZE - 1);

    ibad_pkg::cfg_t              cfg;
    ibad_pkg::state_t            state_reg;
    ibad_pkg::state_t            state_next;
    ibad_pkg::div_req_t          div_req;

    logic                        div_busy;
    logic                        div_done;
    logic [ibad_pkg::ACC_W-1:0]  div_quo;

    logic                        ram_rd_en;
    logic [ibad_pkg::GRID_W-1:0] ram_rd_addr;
    logic [ibad_pkg::ACC_W-1:0]  ram_rd_data;
    logic                        ram_wr_en;
    logic [ibad_pkg::ACC_W-1:0]  ram_wr_data;

    // frame position state
    logic [ibad_pkg::POS_W-1:0]  col_x_reg;
    logic [ibad_pkg::CNT_W-1:0]  pos_reg;
    logic [ibad_pkg::GRID_W-1:0] bin_reg;
    logic [ibad_pkg::ACC_W-1:0]  bin_sum_reg;
    logic [ibad_pkg::POS_W-1:0]  row_y_reg;
    logic [ibad_pkg::GRID_W-1:0] band_reg;
    logic [ibad_pkg::CNT_W-1:0]  band_rows_reg;
    logic [ibad_pkg::GRID_SIZE-1:0] valid_reg;

    // pending work for the current bin end
    logic [ibad_pkg::GRID_W-1:0] acc_bin_reg;
    logic                        band_pend_reg;
    logic                        frame_pend_reg;
    logic [ibad_pkg::GRID_W-1:0] emit_band_reg;
    logic [ibad_pkg::GRID_W-1:0] emit_col_reg;

    // output register
    logic                        out_valid_reg;
    logic [ibad_pkg::PIX_W-1:0]  average_reg;
    logic [ibad_pkg::GRID_W-1:0] out_row_reg;
    logic [ibad_pkg::GRID_W-1:0] out_col_reg;
    logic                        band_last_reg;
    logic                        frame_last_reg;

    // combinational helpers
    logic [ibad_pkg::SIZE_W-1:0] w_clamp;
    logic [ibad_pkg::SIZE_W-1:0] h_clamp;
    logic [ibad_pkg::CNT_W-1:0]  wbase;
    logic [ibad_pkg::CNT_W-1:0]  hbase;
    logic [ibad_pkg::CNT_W-1:0]  bin_size;
    logic [ibad_pkg::PIX_W-1:0]  sample;
    logic [ibad_pkg::ACC_W-1:0]  bin_sum_add;
    logic [ibad_pkg::CNT_W-1:0]  rows_new;
    logic                        accept;
    logic                        last_bin;
    logic                        last_band;
    logic                        row_end;
    logic                        bin_end;
    logic                        frame_end;
    logic                        band_end;
    logic                        slot_free;
    logic                        out_load;
    logic                        emit_done;
    logic [ibad_pkg::ACC_W-1:0]  acc_old;
    logic [ibad_pkg::ACC_W-1:0]  emit_acc;
    logic [ibad_pkg::PIX_W-1:0]  avg_sat;

    ibad_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ibad_acc_ram u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (acc_bin_reg),
        .wr_data (ram_wr_data)
    );

    ibad_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Clamp sizes and derive bin and band base sizes
    always_comb
    begin
        if (cfg.image_width < ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE))
            w_clamp = ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE);
        else if (cfg.image_width > ibad_pkg::SIZE_W'(ibad_pkg::MAX_WIDTH))
            w_clamp = ibad_pkg::SIZE_W'(ibad_pkg::MAX_WIDTH);
        else
            w_clamp = cfg.image_width;

        if (cfg.image_height < ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE))
            h_clamp = ibad_pkg::SIZE_W'(ibad_pkg::MIN_SIZE);
        else if (cfg.image_height > ibad_pkg::SIZE_W'(ibad_pkg::MAX_HEIGHT))
            h_clamp = ibad_pkg::SIZE_W'(ibad_pkg::MAX_HEIGHT);
        else
            h_clamp = cfg.image_height;

        wbase = w_clamp[ibad_pkg::SIZE_W-1:ibad_pkg::GRID_W];
        hbase = h_clamp[ibad_pkg::SIZE_W-1:ibad_pkg::GRID_W];
    end

    // Pick the averaged channel; the unused code falls to blue
    always_comb
    begin
        case (cfg.channel_select)
            ibad_pkg::CH_RED:   sample = red;
            ibad_pkg::CH_GREEN: sample = green;
            default:            sample = blue;
        endcase
    end

    // Position decode for the incoming pixel
    always_comb
    begin
        accept      = in_valid && !in_stall;
        last_bin    = bin_reg == LAST_CELL;
        last_band   = band_reg == LAST_CELL;
        bin_sum_add = bin_sum_reg + ibad_pkg::ACC_W'(sample);
        row_end     = {1'b0, col_x_reg} >= (w_clamp - 1'b1);
        bin_end     = row_end ||
                      (!last_bin && ({1'b0, pos_reg} + 1'b1) == {1'b0, wbase});
        bin_size    = last_bin ? wbase + ibad_pkg::CNT_W'(w_clamp[ibad_pkg::GRID_W-1:0])
                               : wbase;
        rows_new    = band_rows_reg + 1'b1;
        frame_end   = {1'b0, row_y_reg} >= (h_clamp - 1'b1);
        band_end    = frame_end || (!last_band && rows_new == hbase);
    end

    // Accumulator and result arithmetic
    always_comb
    begin
        acc_old     = valid_reg[acc_bin_reg] ? ram_rd_data : '0;
        emit_acc    = valid_reg[emit_col_reg] ? ram_rd_data : '0;
        ram_wr_data = acc_old + div_quo;
        avg_sat     = (|div_quo[ibad_pkg::ACC_W-1:ibad_pkg::PIX_W])
                      ? '1 : div_quo[ibad_pkg::PIX_W-1:0];
        slot_free   = !out_valid_reg || !out_stall;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibad_pkg::S_IDLE:
                if (accept && bin_end)
                    state_next = ibad_pkg::S_BIN_DIV;
            ibad_pkg::S_BIN_DIV:
                if (div_done)
                    state_next = band_pend_reg ? ibad_pkg::S_EMIT_RD : ibad_pkg::S_IDLE;
            ibad_pkg::S_EMIT_RD:
                state_next = ibad_pkg::S_EMIT_START;
            ibad_pkg::S_EMIT_START:
                state_next = ibad_pkg::S_EMIT_DIV;
            ibad_pkg::S_EMIT_DIV:
                if (div_done && slot_free)
                    state_next = (emit_col_reg == LAST_CELL) ? ibad_pkg::S_IDLE
                                                             : ibad_pkg::S_EMIT_RD;
            default:
                state_next = ibad_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall         = 1'b1;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = bin_reg;
        ram_wr_en        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = bin_sum_add;
        div_req.divisor  = bin_size;
        out_load         = 1'b0;
        emit_done        = 1'b0;
        unique case (state_reg)
            ibad_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                ram_rd_en     = accept && bin_end;
                div_req.start = accept && bin_end;
            end
            ibad_pkg::S_BIN_DIV:
                ram_wr_en = div_done;
            ibad_pkg::S_EMIT_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = emit_col_reg;
            end
            ibad_pkg::S_EMIT_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = emit_acc;
                div_req.divisor  = band_rows_reg;
            end
            ibad_pkg::S_EMIT_DIV:
            begin
                out_load  = div_done && slot_free;
                emit_done = div_done && slot_free && emit_col_reg == LAST_CELL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ibad_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance column, bin and row counters per accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_x_reg      <= '0;
            pos_reg        <= '0;
            bin_reg        <= '0;
            bin_sum_reg    <= '0;
            row_y_reg      <= '0;
            band_reg       <= '0;
            band_rows_reg  <= '0;
            valid_reg      <= '0;
            band_pend_reg  <= 1'b0;
            frame_pend_reg <= 1'b0;
            emit_col_reg   <= '0;
        end
        else if (cfg.restart)
        begin
            col_x_reg     <= '0;
            pos_reg       <= '0;
            bin_reg       <= '0;
            bin_sum_reg   <= '0;
            row_y_reg     <= '0;
            band_reg      <= '0;
            band_rows_reg <= '0;
            valid_reg     <= '0;
            band_pend_reg <= 1'b0;
            emit_col_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                bin_sum_reg <= bin_end ? '0 : bin_sum_add;
                if (row_end)
                begin
                    col_x_reg      <= '0;
                    pos_reg        <= '0;
                    bin_reg        <= '0;
                    band_rows_reg  <= rows_new;
                    row_y_reg      <= frame_end ? '0 : row_y_reg + 1'b1;
                    band_pend_reg  <= band_end;
                    frame_pend_reg <= frame_end;
                    if (band_end)
                        band_reg <= frame_end ? '0 : band_reg + 1'b1;
                end
                else
                begin
                    col_x_reg <= col_x_reg + 1'b1;
                    band_pend_reg <= 1'b0;
                    if (bin_end)
                    begin
                        pos_reg <= '0;
                        bin_reg <= bin_reg + 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
            end

            // Mark the accumulator written
            if (ram_wr_en)
                valid_reg[acc_bin_reg] <= 1'b1;

            // Step through the band readout; drop all accumulators at its end
            if (out_load)
            begin
                if (emit_done)
                begin
                    emit_col_reg  <= '0;
                    valid_reg     <= '0;
                    band_rows_reg <= '0;
                    band_pend_reg <= 1'b0;
                end
                else
                begin
                    emit_col_reg <= emit_col_reg + 1'b1;
                end
            end
        end
    end

    // Hold the bin index and band tag of the pending work
    always_ff @(posedge clk)
    begin
        if (accept && bin_end)
        begin
            acc_bin_reg   <= bin_reg;
            emit_band_reg <= band_reg;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            average_reg    <= avg_sat;
            out_row_reg    <= emit_band_reg;
            out_col_reg    <= emit_col_reg;
            band_last_reg  <= emit_col_reg == LAST_CELL;
            frame_last_reg <= (emit_col_reg == LAST_CELL) && frame_pend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign band_last  = band_last_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    // No pixel is taken while the divider works
    a_stall_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> in_stall)
        else $error("pixel accepted during division");

    // The accumulator is written only with a finished quotient
    a_write_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (div_done && !div_busy))
        else $error("accumulator written before division finished");

    // The band closes on the last column
    a_band_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && band_last) |-> (out_col == LAST_CELL))
        else $error("band_last away from last column");

    // The frame closes on the last cell of the last band
    a_frame_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (band_last && out_row == LAST_CELL))
        else $error("frame_last away from last cell");
`endif

endmodule
